FILE: rtl/cfm_pkg.sv
// Package: shared types, codes and constants of the continuity link monitor.
`default_nettype none
package cfm_pkg;

  localparam int MAX_LINKS_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int HB_LIMIT        = 4;

  localparam logic [15:0] ETYPE_CFM     = 16'h8902;
  localparam logic [7:0]  CFM_OP_CCM    = 8'h01;
  localparam logic [12:0] EP_MASK       = 13'h1FFF;
  localparam logic [15:0] INTERVAL_RST  = 16'd100;
  localparam logic [15:0] TIMEOUT_RST   = 16'd350;
  localparam logic [2:0]  LEVEL_RST     = 3'd5;
  localparam logic [15:0] AGE_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_FRAME = 2'd1,
    OP_PROV  = 2'd2,
    OP_NONE  = 2'd3
  } cfm_op_t;

  typedef enum logic [1:0] {
    RX_NONE     = 2'd0,
    RX_LEARNED  = 2'd1,
    RX_REFRESH  = 2'd2,
    RX_MISMATCH = 2'd3
  } cfm_rx_t;

  typedef enum logic {
    EV_STATUS    = 1'b0,
    EV_HEARTBEAT = 1'b1
  } cfm_ev_t;

  typedef enum logic [1:0] {
    REG_INTERVAL = 2'd0,
    REG_TIMEOUT  = 2'd1,
    REG_LEVEL    = 2'd2
  } cfm_reg_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_EXEC,
    FS_EMIT,
    FS_STATUS
  } cfm_fstate_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  link_index;
    logic        frame_long_enough;
    logic [15:0] ether_type;
    logic [7:0]  level_version;
    logic [7:0]  cfm_opcode;
    logic [15:0] endpoint_id;
    logic [47:0] source_address;
    logic [47:0] local_address;
    logic [47:0] peer_address;
    logic        link_enable;
  } cfm_in_t;

  typedef struct packed {
    logic        event_kind;
    logic [1:0]  link_number;
    logic [31:0] sequence_res;
    logic        unicast;
    logic [47:0] destination;
    logic [12:0] own_endpoint;
    logic [1:0]  rx_outcome;
    logic [3:0]  up_mask;
    logic        last_item;
  } cfm_out_t;

  typedef struct packed {
    logic [15:0] interval_ms;
    logic [15:0] timeout_ms;
    logic [2:0]  watched_level;
  } cfm_cfg_t;

  // Endpoint derived from an address: low 13 bits, with zero mapped to one.
  function automatic logic [12:0] endpoint_of(input logic [47:0] addr);
    logic [12:0] e;
    e = addr[12:0] & EP_MASK;
    return (e == 13'd0) ? 13'd1 : e;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cfm_front.sv
// Front part: accepts transactions, updates link state and queues results.
`default_nettype none
module cfm_front #(
  parameter int MAX_LINKS = cfm_pkg::MAX_LINKS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  cfm_pkg::cfm_cfg_t   cfg,
  input  wire                 in_valid,
  output logic                in_stall,
  input  cfm_pkg::cfm_in_t    in_data,
  output logic                push,
  output cfm_pkg::cfm_out_t   push_data,
  input  wire                 full
);
  localparam int IW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;

  cfm_pkg::cfm_fstate_t state, state_next;
  cfm_pkg::cfm_in_t     item;
  logic [1:0]           rx_reg;
  logic [IW-1:0]        idx;
  logic [2:0]           cnt;

  logic [47:0] peer_mac       [MAX_LINKS];
  logic [15:0] peer_endpoint  [MAX_LINKS];
  logic [15:0] receive_age    [MAX_LINKS];
  logic [31:0] tx_sequence    [MAX_LINKS];
  logic [12:0] local_endpoint [MAX_LINKS];
  logic [MAX_LINKS-1:0] peer_known, link_alive, link_active;
  logic [15:0] since_heartbeat;

  logic [15:0] age_inc [MAX_LINKS];
  logic [15:0] since_inc;
  logic        fire, li_ok, frame_ok, hb_needed, advance, is_last;
  logic [IW-1:0] rd_idx;
  logic [3:0]  mask;

  assign in_stall = (state != cfm_pkg::FS_IDLE);
  assign li_ok    = ({30'd0, item.link_index} < MAX_LINKS);
  assign rd_idx   = (state == cfm_pkg::FS_EMIT) ? idx : IW'(item.link_index);
  assign is_last  = (idx == IW'(MAX_LINKS - 1));

  always_comb begin
    for (int i = 0; i < MAX_LINKS; i++) begin
      age_inc[i] = (receive_age[i] == cfm_pkg::AGE_MAX) ? receive_age[i]
                                                        : receive_age[i] + 16'd1;
    end
    since_inc = (since_heartbeat == cfm_pkg::AGE_MAX) ? since_heartbeat
                                                      : since_heartbeat + 16'd1;
    mask = 4'd0;
    for (int i = 0; i < 4; i++) begin
      if (i < MAX_LINKS) mask[i] = link_active[i] && link_alive[i];
    end
  end

  assign fire = (since_inc >= cfg.interval_ms);
  assign frame_ok = item.frame_long_enough && (item.ether_type == cfm_pkg::ETYPE_CFM) &&
                    (item.level_version[7:5] == cfg.watched_level) &&
                    (item.cfm_opcode == cfm_pkg::CFM_OP_CCM) && li_ok &&
                    link_active[rd_idx];
  assign hb_needed = link_active[rd_idx] && (cnt < 3'(cfm_pkg::HB_LIMIT));
  assign advance   = !hb_needed || !full;

  always_ff @(posedge clk) begin
    if (rst) state <= cfm_pkg::FS_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_data  = '0;
    unique case (state)
      cfm_pkg::FS_IDLE: begin
        if (in_valid) state_next = cfm_pkg::FS_EXEC;
      end
      cfm_pkg::FS_EXEC: begin
        if (item.opcode == cfm_pkg::OP_TICK && fire) state_next = cfm_pkg::FS_EMIT;
        else state_next = cfm_pkg::FS_STATUS;
      end
      cfm_pkg::FS_EMIT: begin
        push                   = hb_needed && !full;
        push_data.event_kind   = cfm_pkg::EV_HEARTBEAT;
        push_data.link_number  = 2'(idx);
        push_data.sequence_res = tx_sequence[rd_idx];
        push_data.unicast      = peer_known[rd_idx];
        push_data.destination  = peer_known[rd_idx] ? peer_mac[rd_idx] : 48'd0;
        push_data.own_endpoint = local_endpoint[rd_idx];
        push_data.up_mask      = mask;
        if (advance && is_last) state_next = cfm_pkg::FS_STATUS;
      end
      cfm_pkg::FS_STATUS: begin
        push                  = !full;
        push_data.event_kind  = cfm_pkg::EV_STATUS;
        push_data.link_number = (item.opcode == cfm_pkg::OP_FRAME ||
                                 item.opcode == cfm_pkg::OP_PROV) ? item.link_index : 2'd0;
        push_data.rx_outcome  = rx_reg;
        push_data.up_mask     = mask;
        push_data.last_item   = 1'b1;
        if (!full) state_next = cfm_pkg::FS_IDLE;
      end
      default: state_next = cfm_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == cfm_pkg::FS_IDLE && in_valid) item <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LINKS; i++) begin
        peer_mac[i]       <= '0;
        peer_endpoint[i]  <= '0;
        receive_age[i]    <= '0;
        tx_sequence[i]    <= '0;
        local_endpoint[i] <= '0;
      end
      peer_known      <= '0;
      link_alive      <= '1;
      link_active     <= '0;
      since_heartbeat <= '0;
      rx_reg          <= cfm_pkg::RX_NONE;
      idx             <= '0;
      cnt             <= '0;
    end else begin
      unique case (state)
        cfm_pkg::FS_EXEC: begin
          idx    <= '0;
          cnt    <= '0;
          rx_reg <= cfm_pkg::RX_NONE;
          case (item.opcode)
            cfm_pkg::OP_TICK: begin
              for (int i = 0; i < MAX_LINKS; i++) begin
                receive_age[i] <= age_inc[i];
                // Health is settled up front so every heartbeat sees the final mask.
                if (fire && link_active[i]) begin
                  if (!peer_known[i]) link_alive[i] <= 1'b1;
                  else if (age_inc[i] > cfg.timeout_ms) link_alive[i] <= 1'b0;
                end
              end
              since_heartbeat <= fire ? 16'd0 : since_inc;
            end
            cfm_pkg::OP_FRAME: begin
              if (frame_ok) begin
                if (!peer_known[rd_idx]) begin
                  peer_mac[rd_idx]      <= item.source_address;
                  peer_endpoint[rd_idx] <= item.endpoint_id;
                  peer_known[rd_idx]    <= 1'b1;
                  link_alive[rd_idx]    <= 1'b1;
                  receive_age[rd_idx]   <= '0;
                  rx_reg                <= cfm_pkg::RX_LEARNED;
                end else if (peer_endpoint[rd_idx] == item.endpoint_id &&
                             peer_mac[rd_idx] == item.source_address) begin
                  link_alive[rd_idx]  <= 1'b1;
                  receive_age[rd_idx] <= '0;
                  rx_reg              <= cfm_pkg::RX_REFRESH;
                end else begin
                  rx_reg <= cfm_pkg::RX_MISMATCH;
                end
              end
            end
            cfm_pkg::OP_PROV: begin
              if (li_ok) begin
                local_endpoint[rd_idx] <= cfm_pkg::endpoint_of(item.local_address);
                if (item.peer_address != 48'd0) begin
                  peer_mac[rd_idx]      <= item.peer_address;
                  peer_endpoint[rd_idx] <= {3'd0, cfm_pkg::endpoint_of(item.peer_address)};
                  peer_known[rd_idx]    <= 1'b1;
                end else begin
                  peer_mac[rd_idx]      <= '0;
                  peer_endpoint[rd_idx] <= '0;
                  peer_known[rd_idx]    <= 1'b0;
                end
                receive_age[rd_idx] <= '0;
                tx_sequence[rd_idx] <= '0;
                link_alive[rd_idx]  <= 1'b1;
                link_active[rd_idx] <= item.link_enable;
              end
            end
            default: ;
          endcase
        end
        cfm_pkg::FS_EMIT: begin
          if (advance) begin
            idx <= idx + IW'(1);
            if (link_active[rd_idx]) tx_sequence[rd_idx] <= tx_sequence[rd_idx] + 32'd1;
            if (push) cnt <= cnt + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/cfm_queue.sv
// Short result queue between the front part and the output stage.
`default_nettype none
module cfm_queue #(
  parameter int DEPTH = cfm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  cfm_pkg::cfm_out_t  push_data,
  output logic               full,
  input  wire                pop,
  output cfm_pkg::cfm_out_t  head,
  output logic               empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cfm_pkg::cfm_out_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/cfm_out_stage.sv
// Output register that drains the result queue onto the output channel.
`default_nettype none
module cfm_out_stage (
  input  wire                clk,
  input  wire                rst,
  input  wire                empty,
  input  cfm_pkg::cfm_out_t  head,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_stall,
  output cfm_pkg::cfm_out_t  out_data
);
  assign pop = !empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!out_valid || !out_stall) out_valid <= !empty;
  end

  always_ff @(posedge clk) begin
    if (pop) out_data <= head;
  end
endmodule
`default_nettype wire

FILE: rtl/cfm_continuity_link_monitor.sv
// Top level of the continuity-check link monitor.
//
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  cfm_in_t, one tick, frame, provision or none
// out       output     out_valid/out_stall cfm_out_t, heartbeats then one status
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data (16 bit)
//
// An input transaction passes three steps in the front part (accept, execute,
// queue the status); a tick that fires a heartbeat round adds a step per link
// slot (MAX_LINKS), as the front walks the links through its single table port.
// Reset is synchronous and active high; it resets all link state and loads the
// register defaults (interval 100, timeout 350, level 5).
// The front stalls its input from acceptance until the status is queued, and that
// stretches while the queue is full; the output register keeps draining the queue
// independently of the front.
`default_nettype none
module cfm_continuity_link_monitor #(
  parameter int MAX_LINKS   = cfm_pkg::MAX_LINKS_DEF,
  parameter int QUEUE_DEPTH = cfm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  cfm_pkg::cfm_in_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output cfm_pkg::cfm_out_t  out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [1:0]          cfg_index,
  input  wire [15:0]         cfg_data
);
  cfm_pkg::cfm_cfg_t  cfg;
  cfm_pkg::cfm_out_t  push_data, head;
  logic               q_push, q_full, q_pop, q_empty;

  // Registers are always writable; software must write them only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval_ms   <= cfm_pkg::INTERVAL_RST;
      cfg.timeout_ms    <= cfm_pkg::TIMEOUT_RST;
      cfg.watched_level <= cfm_pkg::LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfm_pkg::REG_INTERVAL: cfg.interval_ms   <= cfg_data;
        cfm_pkg::REG_TIMEOUT:  cfg.timeout_ms    <= cfg_data;
        cfm_pkg::REG_LEVEL:    cfg.watched_level <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Front part: classifies each transaction, updates state, queues results.
  cfm_front #(.MAX_LINKS(MAX_LINKS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full)
  );

  cfm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty)
  );

  // Back part: output register fed from the queue.
  cfm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full && !q_pop)) else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty)) else $error("pop from an empty queue");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("front took two transactions");

endmodule
`default_nettype wire

FILE: bench/tb_cfm_continuity_link_monitor.sv
// Testbench for the continuity link monitor: random and directed transactions checked by a predictor.
`default_nettype none
module tb_cfm_continuity_link_monitor;

  localparam int NLINK = 4;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  cfm_pkg::cfm_in_t in_data;
  logic out_valid;
  logic out_stall;
  cfm_pkg::cfm_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  cfm_continuity_link_monitor u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the monitor's registers and per-link tables.
  logic [15:0] sh_interval;
  logic [15:0] sh_timeout;
  logic [2:0] sh_level;
  logic [47:0] sh_peer_mac [NLINK];
  logic [15:0] sh_peer_ep [NLINK];
  logic sh_known [NLINK];
  logic sh_alive [NLINK];
  logic [15:0] sh_age [NLINK];
  logic [31:0] sh_seq [NLINK];
  logic sh_active [NLINK];
  logic [12:0] sh_local_ep [NLINK];
  logic [15:0] sh_since;

  cfm_pkg::cfm_in_t pending_items[$];
  cfm_pkg::cfm_out_t expected_events[$];
  int errors;
  logic hold_req;      // asks the hold-off process for a long receiver stall
  int hold_off;        // long receiver hold-off, counted down in its own process
  int send_gap;
  int recv_gap;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input cfm_pkg::cfm_out_t got,
                                 input cfm_pkg::cfm_out_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [12:0] addr_endpoint(input logic [47:0] a);
    logic [12:0] e;
    e = a[12:0];
    return (e == 13'd0) ? 13'd1 : e;
  endfunction

  function automatic logic [3:0] current_up();
    logic [3:0] m;
    m = '0;
    for (int i = 0; i < NLINK; i++) m[i] = sh_active[i] && sh_alive[i];
    return m;
  endfunction

  // Works out the heartbeats and the status a transaction produces, updating the shadow.
  task automatic predict_events(input cfm_pkg::cfm_in_t it);
    cfm_pkg::cfm_out_t ev;
    cfm_pkg::cfm_out_t batch[$];
    cfm_pkg::cfm_rx_t outcome;
    logic [1:0] li;
    logic [1:0] status_link;
    logic ok;
    outcome = cfm_pkg::RX_NONE;
    li = it.link_index;
    status_link = 2'd0;
    if (it.opcode == cfm_pkg::OP_TICK) begin
      for (int i = 0; i < NLINK; i++) if (sh_age[i] != cfm_pkg::AGE_MAX) sh_age[i]++;
      if (sh_since != cfm_pkg::AGE_MAX) sh_since++;
      if (sh_since >= sh_interval) begin
        sh_since = '0;
        for (int i = 0; i < NLINK; i++) begin
          if (sh_active[i]) begin
            ev = '0;
            ev.event_kind = cfm_pkg::EV_HEARTBEAT;
            ev.link_number = i[1:0];
            ev.sequence_res = sh_seq[i];
            ev.unicast = sh_known[i];
            ev.destination = sh_known[i] ? sh_peer_mac[i] : 48'd0;
            ev.own_endpoint = sh_local_ep[i];
            batch.push_back(ev);
            sh_seq[i]++;
            if (sh_known[i]) begin
              if (sh_age[i] > sh_timeout) sh_alive[i] = 1'b0;
            end else begin
              sh_alive[i] = 1'b1;
            end
          end
        end
      end
    end else if (it.opcode == cfm_pkg::OP_FRAME) begin
      status_link = li;
      ok = it.frame_long_enough && it.ether_type == cfm_pkg::ETYPE_CFM &&
           it.level_version[7:5] == sh_level && it.cfm_opcode == cfm_pkg::CFM_OP_CCM &&
           sh_active[li];
      if (ok) begin
        if (!sh_known[li]) begin
          sh_peer_mac[li] = it.source_address;
          sh_peer_ep[li] = it.endpoint_id;
          sh_known[li] = 1'b1;
          sh_alive[li] = 1'b1;
          sh_age[li] = '0;
          outcome = cfm_pkg::RX_LEARNED;
        end else if (sh_peer_ep[li] == it.endpoint_id &&
                     sh_peer_mac[li] == it.source_address) begin
          sh_age[li] = '0;
          sh_alive[li] = 1'b1;
          outcome = cfm_pkg::RX_REFRESH;
        end else begin
          outcome = cfm_pkg::RX_MISMATCH;
        end
      end
    end else if (it.opcode == cfm_pkg::OP_PROV) begin
      status_link = li;
      sh_local_ep[li] = addr_endpoint(it.local_address);
      sh_known[li] = it.peer_address != 48'd0;
      sh_peer_mac[li] = it.peer_address;
      sh_peer_ep[li] = sh_known[li] ? {3'd0, addr_endpoint(it.peer_address)} : 16'd0;
      sh_age[li] = '0;
      sh_seq[li] = '0;
      sh_alive[li] = 1'b1;
      sh_active[li] = it.link_enable;
    end
    ev = '0;
    ev.event_kind = cfm_pkg::EV_STATUS;
    ev.link_number = status_link;
    ev.rx_outcome = outcome;
    ev.last_item = 1'b1;
    batch.push_back(ev);
    foreach (batch[k]) begin
      batch[k].up_mask = current_up();
      expected_events.push_back(batch[k]);
    end
  endtask

  // Driver: offers queued transactions with random gaps; the payload holds while stalled.
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap <= 0;
    end else if (in_valid && !in_stall) begin
      predict_events(in_data);
      void'(pending_items.pop_front());
      gap = $urandom_range(0, 3);
      if (gap == 0 && pending_items.size() > 0) begin
        in_data <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
      send_gap <= gap;
    end else if (!in_valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
      end
    end
  end

  // Long receiver hold-off, counted here in cycles.
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 0;
    end else if (hold_req) begin
      hold_off <= 300;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    cfm_pkg::cfm_out_t want;
    int gap;
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
    end else begin
      gap = 0;
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected result", out_data, '0);
        end else begin
          want = expected_events.pop_front();
          if (out_data !== want) report_mismatch("result", out_data, want);
        end
        gap = $urandom_range(0, 3);
      end
      // The long hold-off wins over the per-result gap draw.
      if (hold_off > 0) begin
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_stall <= (gap != 0);
        recv_gap <= (gap > 0) ? gap - 1 : 0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic cfm_pkg::cfm_in_t rand_item();
    cfm_pkg::cfm_in_t it;
    logic [223:0] raw;
    int pick;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(cfm_pkg::cfm_in_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.opcode = cfm_pkg::OP_TICK;
    end else if (pick < 85) begin
      // Mostly well-formed CCMs so that learning and refresh are reached.
      it.opcode = cfm_pkg::OP_FRAME;
      if ($urandom_range(0, 4) != 0) begin
        it.frame_long_enough = 1'b1;
        it.ether_type = cfm_pkg::ETYPE_CFM;
        it.level_version[7:5] = sh_level;
        it.cfm_opcode = cfm_pkg::CFM_OP_CCM;
        if ($urandom_range(0, 3) != 0) begin
          it.source_address = {46'd0, it.link_index} + 48'h0000_1234_0000;
          it.endpoint_id = {14'd0, it.link_index} + 16'd10;
        end
      end
    end else if (pick < 97) begin
      it.opcode = cfm_pkg::OP_PROV;
      if ($urandom_range(0, 1)) it.peer_address = '0;
      else if ($urandom_range(0, 1))
        it.peer_address = {46'd0, it.link_index} + 48'h0000_1234_0000;
      it.link_enable = ($urandom_range(0, 4) != 0);
    end else begin
      it.opcode = cfm_pkg::OP_NONE;
    end
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_events.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input cfm_pkg::cfm_reg_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cfm_pkg::REG_INTERVAL: sh_interval = val;
      cfm_pkg::REG_TIMEOUT:  sh_timeout = val;
      default:               sh_level = val[2:0];
    endcase
  endtask

  task automatic set_regs(input logic [15:0] ivl, input logic [15:0] tmo,
                          input logic [2:0] lvl);
    wait_drained();
    write_reg(cfm_pkg::REG_INTERVAL, ivl);
    write_reg(cfm_pkg::REG_TIMEOUT, tmo);
    write_reg(cfm_pkg::REG_LEVEL, {13'd0, lvl});
  endtask

  function automatic cfm_pkg::cfm_in_t make_item(input cfm_pkg::cfm_op_t op,
                                                 input logic [1:0] li);
    cfm_pkg::cfm_in_t it;
    it = '0;
    it.opcode = op;
    it.link_index = li;
    return it;
  endfunction

  initial begin
    cfm_pkg::cfm_in_t it;
    errors = 0;
    hold_req = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = cfm_pkg::REG_INTERVAL;
    cfg_data = '0;
    sh_interval = cfm_pkg::INTERVAL_RST;
    sh_timeout = cfm_pkg::TIMEOUT_RST;
    sh_level = cfm_pkg::LEVEL_RST;
    sh_since = '0;
    for (int i = 0; i < NLINK; i++) begin
      sh_peer_mac[i] = '0; sh_peer_ep[i] = '0; sh_known[i] = 1'b0; sh_alive[i] = 1'b1;
      sh_age[i] = '0; sh_seq[i] = '0; sh_active[i] = 1'b0; sh_local_ep[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part under small interval and timeout: heartbeats on every tick.
    set_regs(16'd1, 16'd0, 3'd7);
    for (int l = 0; l < NLINK; l++) begin
      it = make_item(cfm_pkg::OP_PROV, l[1:0]);
      it.local_address = (l == 0) ? 48'hFFFF_FFFF_E000 : 48'hFFFF_FFFF_FFFF;
      it.peer_address = (l == 1) ? 48'hFFFF_FFFF_FFFF : 48'd0;
      it.link_enable = 1'b1;
      pending_items.push_back(it);
    end
    // Good CCM learns, repeat refreshes, different source mismatches.
    it = make_item(cfm_pkg::OP_FRAME, 2'd2);
    it.frame_long_enough = 1'b1; it.ether_type = cfm_pkg::ETYPE_CFM;
    it.level_version = 8'hFF; it.cfm_opcode = cfm_pkg::CFM_OP_CCM;
    it.endpoint_id = 16'hFFFF; it.source_address = 48'hFFFF_FFFF_FFFF;
    pending_items.push_back(it);
    pending_items.push_back(it);
    it.source_address = 48'h0; pending_items.push_back(it);
    it.source_address = 48'hFFFF_FFFF_FFFF; it.ether_type = 16'h8903;
    pending_items.push_back(it);
    it.ether_type = cfm_pkg::ETYPE_CFM; it.level_version = 8'h1F;
    pending_items.push_back(it);
    it.level_version = 8'hE0; it.cfm_opcode = 8'h02; pending_items.push_back(it);
    it.cfm_opcode = cfm_pkg::CFM_OP_CCM; it.frame_long_enough = 1'b0;
    pending_items.push_back(it);
    repeat (3) pending_items.push_back(make_item(cfm_pkg::OP_TICK, 2'd3));
    pending_items.push_back(make_item(cfm_pkg::OP_NONE, 2'd1));
    it = make_item(cfm_pkg::OP_PROV, 2'd3); pending_items.push_back(it);
    it = make_item(cfm_pkg::OP_FRAME, 2'd3); it.frame_long_enough = 1'b1;
    it.ether_type = cfm_pkg::ETYPE_CFM; it.level_version = 8'hE0;
    it.cfm_opcode = cfm_pkg::CFM_OP_CCM;
    pending_items.push_back(it);
    pending_items.push_back(make_item(cfm_pkg::OP_TICK, 2'd0));

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(16'd3, 16'd4, 3'd5);
        1: set_regs(16'd2, 16'd65534, 3'd0);
        2: set_regs(16'd65535, 16'd2, 3'd3);
        3: set_regs(16'd1, 16'd1, 3'd7);
        4: set_regs(16'd5, 16'd12, 3'd2);
        default: set_regs(cfm_pkg::INTERVAL_RST, cfm_pkg::TIMEOUT_RST, cfm_pkg::LEVEL_RST);
      endcase
      for (int n = 0; n < 65; n++) pending_items.push_back(rand_item());
      if (ph == 1) begin
        // Long receiver hold-off while the sender keeps offering transactions.
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      if (ph == 3) begin
        // The sender pauses until every expected result has arrived.
        while (pending_items.size() > 30) @(posedge clk);
        wait_drained();
        for (int n = 0; n < 20; n++) pending_items.push_back(rand_item());
      end
    end
    wait_drained();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

FILE: cfm_continuity_link_monitor.f
rtl/cfm_pkg.sv
rtl/cfm_front.sv
rtl/cfm_queue.sv
rtl/cfm_out_stage.sv
rtl/cfm_continuity_link_monitor.sv
bench/tb_cfm_continuity_link_monitor.sv
